// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define DCPG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define DCPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/core/dcpg_pkg.sv
// Types and constants of the duty cycle pattern generator.
// No dependencies; compiled before every other file of the block.
package dcpg_pkg;

  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 24;
  localparam int DUTY_W   = 7;
  localparam int REPEAT_W = 16;
  localparam int MODE_W   = 2;
  localparam int EVENT_W  = 2;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = PERIOD_W + DUTY_W;

  localparam logic [MODE_W-1:0] MODE_POLL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT    = 2'd2;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_OFF  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_ON   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000;
  localparam logic [DUTY_W-1:0]   DUTY_RST   = 7'd50;
  localparam logic [REPEAT_W-1:0] REPEAT_RST = 16'd0;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd99;
  localparam logic [DUTY_W-1:0] PERCENT  = 7'd100;

  // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^31
  localparam logic [31:0] RECIP_MUL   = 32'd2748779070;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic [TICK_W-1:0]   phase_start;
    logic [TICK_W-1:0]   phase_elapsed;
    logic                phase_running;
    logic [PERIOD_W-1:0] phase_length;
    logic                in_off_phase;
    logic [REPEAT_W-1:0] cycles_done;
    logic                all_done;
  } dcpg_state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] on_len;
    logic [PERIOD_W-1:0] off_len;
  } dcpg_len_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic               finished;
    logic [TICK_W-1:0]  elapsed_ticks;
  } dcpg_result_t;

endpackage

// File: rtl/core/dcpg_in_if.sv
// Poll channel: valid/ready handshake carrying mode and tick.
// Depends on dcpg_pkg.
interface dcpg_in_if;
  import dcpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TICK_W-1:0] now_tick;

  modport source(output valid, output mode, output now_tick, input ready);
  modport sink(input valid, input mode, input now_tick, output ready);
endinterface

// File: rtl/core/dcpg_out_if.sv
// Status channel: valid/ready handshake carrying the per-poll result.
// Depends on dcpg_pkg.
interface dcpg_out_if;
  import dcpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic               finished;
  logic [TICK_W-1:0]  elapsed_ticks;

  modport source(output valid, output event_res, output finished, output elapsed_ticks,
                 input ready);
  modport sink(input valid, input event_res, input finished, input elapsed_ticks,
               output ready);
endinterface

// File: rtl/core/dcpg_len.sv
// Phase length scaler: period * percent / 100 for the on and off phases.
// Two register stages; depends on dcpg_pkg.
module dcpg_len (
  input  logic                     clk,
  input  logic [dcpg_pkg::PERIOD_W-1:0] period_ms,
  input  logic [dcpg_pkg::DUTY_W-1:0]   duty_percent,
  output dcpg_pkg::dcpg_len_t           lens
);
  import dcpg_pkg::*;

  logic [DUTY_W-1:0]  duty_sat;
  logic [DUTY_W-1:0]  off_pct;
  logic [PROD_W-1:0]  prod_on;
  logic [PROD_W-1:0]  prod_off;
  logic [PROD_W+31:0] scaled_on;
  logic [PROD_W+31:0] scaled_off;

  assign duty_sat = (duty_percent > DUTY_MAX) ? DUTY_MAX : duty_percent;
  assign off_pct  = PERCENT - duty_sat;

  // divide by 100 as a reciprocal multiply
  assign scaled_on  = {32'd0, prod_on} * {{PROD_W{1'b0}}, RECIP_MUL};
  assign scaled_off = {32'd0, prod_off} * {{PROD_W{1'b0}}, RECIP_MUL};

  always_ff @(posedge clk) begin
    prod_on      <= PROD_W'({{DUTY_W{1'b0}}, period_ms} * {{PERIOD_W{1'b0}}, duty_sat});
    prod_off     <= PROD_W'({{DUTY_W{1'b0}}, period_ms} * {{PERIOD_W{1'b0}}, off_pct});
    lens.on_len  <= scaled_on[RECIP_SHIFT +: PERIOD_W];
    lens.off_len <= scaled_off[RECIP_SHIFT +: PERIOD_W];
  end
endmodule

// File: rtl/core/dcpg_step.sv
// Next-state and result logic for one poll, restart or init item.
// Purely combinational; depends on dcpg_pkg.
module dcpg_step (
  input  dcpg_pkg::dcpg_state_t         cur,
  input  dcpg_pkg::dcpg_len_t           lens,
  input  logic [dcpg_pkg::REPEAT_W-1:0] repeat_count,
  input  logic [dcpg_pkg::MODE_W-1:0]   mode,
  input  logic [dcpg_pkg::TICK_W-1:0]   now_tick,
  output dcpg_pkg::dcpg_state_t         nxt,
  output dcpg_pkg::dcpg_result_t        res
);
  import dcpg_pkg::*;

  logic [TICK_W-1:0] start_run;
  logic [TICK_W-1:0] elapsed_run;
  logic              phase_end;

  // a stopped timer resumes where it left off
  assign start_run   = cur.phase_running ? cur.phase_start : now_tick - cur.phase_elapsed;
  assign elapsed_run = now_tick - start_run;
  assign phase_end   = elapsed_run >= {{(TICK_W-PERIOD_W){1'b0}}, cur.phase_length};

  always_comb begin
    nxt           = cur;
    res.event_res = EV_NONE;
    res.finished  = 1'b0;
    unique case (mode)
      MODE_INIT: begin
        nxt.all_done      = 1'b0;
        nxt.cycles_done   = '0;
        nxt.in_off_phase  = 1'b0;
        nxt.phase_start   = '0;
        nxt.phase_elapsed = '0;
        nxt.phase_running = 1'b0;
        nxt.phase_length  = lens.on_len;
      end
      MODE_RESTART: begin
        nxt.all_done    = 1'b0;
        nxt.cycles_done = '0;
      end
      MODE_POLL: begin
        if (cur.all_done) begin
          res.finished = 1'b1;
        end else if (cur.cycles_done == repeat_count) begin
          nxt.all_done = 1'b1;
          res.finished = 1'b1;
        end else begin
          nxt.phase_running = 1'b1;
          if (phase_end) begin
            nxt.phase_start   = now_tick;
            nxt.phase_elapsed = '0;
            if (!cur.in_off_phase) begin
              res.event_res    = EV_OFF;
              nxt.in_off_phase = 1'b1;
              nxt.phase_length = lens.off_len;
            end else begin
              res.event_res    = EV_ON;
              nxt.in_off_phase = 1'b0;
              nxt.phase_length = lens.on_len;
              nxt.cycles_done  = cur.cycles_done + 1'b1;
            end
          end else begin
            nxt.phase_start   = start_run;
            nxt.phase_elapsed = elapsed_run;
          end
        end
      end
      default: begin
        res.finished = cur.all_done;
      end
    endcase
    res.elapsed_ticks = nxt.phase_elapsed;
  end
endmodule

// File: rtl/core/duty_cycle_pattern_generator.sv
// Duty cycle pattern generator, top level.
// Depends on dcpg_pkg, dcpg_in_if, dcpg_out_if, dcpg_len and dcpg_step.
//
// Usage:
//   poll   - valid/ready channel; mode (poll, restart, init) and now_tick.
//   status - valid/ready channel; event_res, finished, elapsed_ticks.
//            Exactly one status transfer per poll transfer, in order.
//   cfg_we/cfg_index/cfg_data - register writes (period, duty, repeats),
//            issued only while no poll is in flight.
// A transferred poll is held in the input register, and its result is then
//   registered in the status register; the phase timer compare and update sit
//   between the two. Throughput: one poll per cycle while status does not stall.
// The on/off lengths come from a two-stage multiply and reciprocal scale
//   of the configuration; poll.ready drops during a register write and for
//   one cycle after it, and for one cycle after reset.
// Reset clears the phase timer, cycle count and both pipeline slots and
//   loads period 1000, duty 50, repeats 0.
// When status stalls, the pending poll waits in the input register and
//   poll.ready falls until the status transfer frees the output.
module duty_cycle_pattern_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dcpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcpg_pkg::CFG_W-1:0]     cfg_data,
  dcpg_in_if.sink                        poll,
  dcpg_out_if.source                     status
);
  import dcpg_pkg::*;

  logic [PERIOD_W-1:0] period_ms;
  logic [DUTY_W-1:0]   duty_percent;
  logic [REPEAT_W-1:0] repeat_count;
  logic                cfg_settle;

  logic                s0_valid;
  logic [MODE_W-1:0]   s0_mode;
  logic [TICK_W-1:0]   s0_tick;

  dcpg_state_t         state;
  dcpg_state_t         state_next;
  dcpg_len_t           lens;
  dcpg_result_t        res;
  dcpg_result_t        res_next;
  logic                res_valid;
  logic                advance;
  logic                poll_xfer;

  assign advance    = s0_valid && (!res_valid || status.ready);
  assign poll.ready = (!s0_valid || advance) && !cfg_settle && !cfg_we;
  assign poll_xfer  = poll.valid && poll.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms    <= PERIOD_RST;
      duty_percent <= DUTY_RST;
      repeat_count <= REPEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD: period_ms    <= cfg_data[PERIOD_W-1:0];
        CFG_DUTY:   duty_percent <= cfg_data[DUTY_W-1:0];
        CFG_REPEAT: repeat_count <= cfg_data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  dcpg_len u_len (
    .clk          (clk),
    .period_ms    (period_ms),
    .duty_percent (duty_percent),
    .lens         (lens)
  );

  dcpg_step u_step (
    .cur          (state),
    .lens         (lens),
    .repeat_count (repeat_count),
    .mode         (s0_mode),
    .now_tick     (s0_tick),
    .nxt          (state_next),
    .res          (res_next)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_settle <= 1'b1;
      s0_valid   <= 1'b0;
      res_valid  <= 1'b0;
      state      <= '0;
    end else begin
      cfg_settle <= cfg_we;
      if (poll_xfer) begin
        s0_valid <= 1'b1;
      end else if (advance) begin
        s0_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (status.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (poll_xfer) begin
      s0_mode <= poll.mode;
      s0_tick <= poll.now_tick;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign status.valid         = res_valid;
  assign status.event_res     = res.event_res;
  assign status.finished      = res.finished;
  assign status.elapsed_ticks = res.elapsed_ticks;
endmodule

// File: rtl/core/dcpg_checker.sv
// Port-level checks for the duty cycle pattern generator, plus the bind.
// Depends on dcpg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcpg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          status_valid,
  input logic                          status_ready,
  input logic [dcpg_pkg::EVENT_W-1:0]  event_res,
  input logic                          finished,
  input logic [dcpg_pkg::TICK_W-1:0]   elapsed_ticks
);
  import dcpg_pkg::*;

  logic stalled;
  logic fin_seen;
  logic ev_fired;
  logic ev_known;

  assign stalled  = status_valid && !status_ready;
  assign fin_seen = status_valid && finished;
  assign ev_fired = status_valid && event_res != EV_NONE;
  assign ev_known = event_res == EV_NONE || event_res == EV_OFF || event_res == EV_ON;

  // a pending status waits for its transfer
  `DCPG_ASSERT(a_status_hold, clk, rst, stalled |=> status_valid, "status dropped while stalled")
  // done reports never carry an edge event
  `DCPG_ASSERT(a_fin_no_event, clk, rst, fin_seen |-> event_res == EV_NONE, "finished with event")
  // a phase switch restarts the phase timer
  `DCPG_ASSERT(a_event_zero, clk, rst, ev_fired |-> elapsed_ticks == '0, "event with elapsed")
  `DCPG_ASSERT(a_event_code, clk, rst, status_valid |-> ev_known, "undefined event code")
  `DCPG_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !status_valid, "status valid after reset")
endmodule

bind duty_cycle_pattern_generator dcpg_checker u_dcpg_checker (
  .clk           (clk),
  .rst           (rst),
  .status_valid  (status.valid),
  .status_ready  (status.ready),
  .event_res     (status.event_res),
  .finished      (status.finished),
  .elapsed_ticks (status.elapsed_ticks)
);
